>>> sv/ts_packet_continuity_checker_top_macros.svh
// assertion helpers for the continuity checker
`ifndef TS_PACKET_CONTINUITY_CHECKER_TOP_MACROS_SVH
`define TS_PACKET_CONTINUITY_CHECKER_TOP_MACROS_SVH

// checked on every clock edge, suspended while reset is high
`define TSPCC_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define TSPCC_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

>>> sv/tspcc_pkg.sv
package tspcc_pkg;

   localparam int PID_ENTRIES = 8192;
   localparam int PID_BITS    = $clog2(PID_ENTRIES);
   localparam int COUNT_BITS  = 32;
   localparam int CC_BITS     = 4;
   localparam int ENTRY_BITS  = CC_BITS + 1;

   localparam logic [7:0]  SYNC_VALUE = 8'h47;
   localparam logic [12:0] PID_NULL   = 13'h1fff;

   typedef enum logic [1:0] {
      ST_ACCEPTED  = 2'd0,
      ST_SYNC_LOSS = 2'd1,
      ST_NULL_DROP = 2'd2
   } packet_status_type;

   typedef struct packed {
      logic [7:0]         sync_code;
      logic [12:0]        packet_pid;
      logic [1:0]         adapt_control;
      logic [CC_BITS-1:0] cont_counter;
      logic [7:0]         adapt_length;
      logic               adapt_discontinuity;
      logic               adapt_pcr_present;
   } header_type;

   typedef struct packed {
      packet_status_type packet_status;
      logic              cc_error;
      logic              disc_seen;
      logic              pcr_seen;
      logic [31:0]       packet_index;
      logic [31:0]       cc_error_total;
      logic [31:0]       sync_loss_total;
   } result_type;

endpackage

>>> sv/tspcc_req_if.sv
interface tspcc_req_if
   import tspcc_pkg::*;
   ;
   logic               valid;
   logic               ready;
   logic [7:0]         sync_code;
   logic [12:0]        packet_pid;
   logic [1:0]         adapt_control;
   logic [CC_BITS-1:0] cont_counter;
   logic [7:0]         adapt_length;
   logic               adapt_discontinuity;
   logic               adapt_pcr_present;

   modport source (
      output valid, sync_code, packet_pid, adapt_control, cont_counter,
             adapt_length, adapt_discontinuity, adapt_pcr_present,
      input  ready
   );

   modport sink (
      input  valid, sync_code, packet_pid, adapt_control, cont_counter,
             adapt_length, adapt_discontinuity, adapt_pcr_present,
      output ready
   );
endinterface

>>> sv/tspcc_rsp_if.sv
interface tspcc_rsp_if
   import tspcc_pkg::*;
   ;
   logic        valid;
   logic        ready;
   logic [1:0]  packet_status;
   logic        cc_error;
   logic        disc_seen;
   logic        pcr_seen;
   logic [31:0] packet_index;
   logic [31:0] cc_error_total;
   logic [31:0] sync_loss_total;

   modport source (
      output valid, packet_status, cc_error, disc_seen, pcr_seen, packet_index,
             cc_error_total, sync_loss_total,
      input  ready
   );

   modport sink (
      input  valid, packet_status, cc_error, disc_seen, pcr_seen, packet_index,
             cc_error_total, sync_loss_total,
      output ready
   );
endinterface

>>> sv/tspcc_ram.sv
module tspcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // a read at the address being written returns the old contents
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ts_packet_continuity_checker_top.sv
// Transport stream continuity checker.
// req_chan carries the header fields of one transport packet per transfer;
// rsp_chan returns one result per packet, in order: status (accepted, sync
// loss, null dropped), continuity error, discontinuity and PCR flags, and the
// running packet index, continuity error total and sync loss total.
// Throughput: one packet per cycle while results are taken. The per-PID table
// sits in a single-port read / single-port write RAM; a packet reads its entry
// on the accept edge, is checked in the next cycle and, unless sync is lost or
// the PID is null, writes the entry back as it leaves the checking stage, with
// that write forwarded to a packet that read the same PID at that edge.
// A packet passes the checking stage register, then the output register.
// Reset: synchronous, active high. Counters and the packet index return to
// zero, then the PID table is swept to zero, one entry per cycle, over all
// PID_ENTRIES (8192) entries; req_chan.ready stays low during the sweep.
// Stall: the result waits in an output register; with it full and not taken
// the checking stage holds and req_chan.ready drops in the same cycle.
`include "ts_packet_continuity_checker_top_macros.svh"

module ts_packet_continuity_checker_top
   import tspcc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   tspcc_req_if.sink      req_chan,
   tspcc_rsp_if.source    rsp_chan
);

   logic                  clearing_ff, clearing_in;
   logic [PID_BITS-1:0]   clr_addr_ff, clr_addr_in;

   logic                  s1_valid_ff, s1_valid_in;
   header_type            s1_hdr_ff;
   logic                  fwd_hit_ff, fwd_hit_in;
   logic [ENTRY_BITS-1:0] fwd_entry_ff;

   logic                  out_valid_ff, out_valid_in;
   result_type            out_ff;

   logic [COUNT_BITS-1:0] index_ff, index_in;
   logic [COUNT_BITS-1:0] err_cnt_ff, err_cnt_in;
   logic [COUNT_BITS-1:0] sync_cnt_ff, sync_cnt_in;

   header_type            req_hdr;
   logic                  accept;
   logic                  s1_adv;
   logic [PID_BITS-1:0]   req_slot;
   logic [PID_BITS-1:0]   s1_slot;

   logic [ENTRY_BITS-1:0] ram_rd_data;
   logic                  ram_wr_en;
   logic [PID_BITS-1:0]   ram_wr_addr;
   logic [ENTRY_BITS-1:0] ram_wr_data;

   logic [ENTRY_BITS-1:0] entry;
   logic                  sync_bad;
   logic                  checked;
   logic                  adapt_field;
   logic                  disc_hit;
   logic                  pcr_hit;
   logic [CC_BITS-1:0]    expect_cc;
   logic                  cc_err;
   logic [ENTRY_BITS-1:0] new_entry;
   result_type            result;

   assign req_hdr = '{
      sync_code:           req_chan.sync_code,
      packet_pid:          req_chan.packet_pid,
      adapt_control:       req_chan.adapt_control,
      cont_counter:        req_chan.cont_counter,
      adapt_length:        req_chan.adapt_length,
      adapt_discontinuity: req_chan.adapt_discontinuity,
      adapt_pcr_present:   req_chan.adapt_pcr_present
   };

   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !clearing_ff && (!s1_valid_ff || s1_adv);
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_slot = req_hdr.packet_pid[PID_BITS-1:0];
   assign s1_slot  = s1_hdr_ff.packet_pid[PID_BITS-1:0];

   // checking stage
   always_comb begin
      entry       = fwd_hit_ff ? fwd_entry_ff : ram_rd_data;
      sync_bad    = s1_hdr_ff.sync_code != SYNC_VALUE;
      checked     = !sync_bad && (s1_hdr_ff.packet_pid != PID_NULL);
      adapt_field = s1_hdr_ff.adapt_control[1] && (s1_hdr_ff.adapt_length != 8'd0);
      disc_hit    = checked && adapt_field && s1_hdr_ff.adapt_discontinuity;
      pcr_hit     = checked && adapt_field && s1_hdr_ff.adapt_pcr_present;
      expect_cc   = entry[CC_BITS-1:0] + CC_BITS'(s1_hdr_ff.adapt_control[0]);
      cc_err      = checked && !disc_hit && entry[CC_BITS]
                    && (s1_hdr_ff.cont_counter != expect_cc);
      new_entry   = {1'b1, s1_hdr_ff.cont_counter};
   end

   always_comb begin
      index_in    = index_ff;
      err_cnt_in  = err_cnt_ff;
      sync_cnt_in = sync_cnt_ff;
      if (s1_adv) begin
         index_in = index_ff + COUNT_BITS'(1);
         if (sync_bad) begin
            sync_cnt_in = sync_cnt_ff + COUNT_BITS'(1);
         end
         if (cc_err) begin
            err_cnt_in = err_cnt_ff + COUNT_BITS'(1);
         end
      end
   end

   always_comb begin
      result.packet_status   = sync_bad ? ST_SYNC_LOSS :
                               (checked ? ST_ACCEPTED : ST_NULL_DROP);
      result.cc_error        = cc_err;
      result.disc_seen       = disc_hit;
      result.pcr_seen        = pcr_hit;
      result.packet_index    = 32'(index_in);
      result.cc_error_total  = 32'(err_cnt_in);
      result.sync_loss_total = 32'(sync_cnt_in);
   end

   // table write port: clearing sweep after reset, else the write-back
   always_comb begin
      if (clearing_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = s1_adv && checked;
         ram_wr_addr = s1_slot;
         ram_wr_data = new_entry;
      end
   end

   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + PID_BITS'(1);
         if (clr_addr_ff == PID_BITS'(PID_ENTRIES - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // forward the write-back to a packet whose read shares its edge
   always_comb begin
      s1_valid_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      fwd_hit_in  = fwd_hit_ff;
      if (accept) begin
         fwd_hit_in = s1_adv && checked && (s1_slot == req_slot);
      end else if (s1_adv) begin
         fwd_hit_in = 1'b0;
      end
      out_valid_in = s1_adv ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_hit_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         index_ff     <= '0;
         err_cnt_ff   <= '0;
         sync_cnt_ff  <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         out_valid_ff <= out_valid_in;
         index_ff     <= index_in;
         err_cnt_ff   <= err_cnt_in;
         sync_cnt_ff  <= sync_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hdr_ff    <= req_hdr;
         fwd_entry_ff <= new_entry;
      end
      if (s1_adv) begin
         out_ff <= result;
      end
   end

   tspcc_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (PID_ENTRIES)
   ) u_pid_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_slot),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.valid           = out_valid_ff;
   assign rsp_chan.packet_status   = out_ff.packet_status;
   assign rsp_chan.cc_error        = out_ff.cc_error;
   assign rsp_chan.disc_seen       = out_ff.disc_seen;
   assign rsp_chan.pcr_seen        = out_ff.pcr_seen;
   assign rsp_chan.packet_index    = out_ff.packet_index;
   assign rsp_chan.cc_error_total  = out_ff.cc_error_total;
   assign rsp_chan.sync_loss_total = out_ff.sync_loss_total;

   `TSPCC_ASSERT_ALWAYS(a_no_work_while_clearing,
      clearing_ff |-> (!s1_valid_ff && !out_valid_ff && !req_chan.ready),
      "packet in flight during table clearing")
   `TSPCC_ASSERT(a_index_steps,
      s1_adv |=> (out_ff.packet_index == 32'($past(index_ff) + COUNT_BITS'(1))),
      "packet index did not advance by one")
   `TSPCC_ASSERT(a_sync_count_tracks_status,
      s1_adv |=> ((out_ff.sync_loss_total != 32'($past(sync_cnt_ff)))
                  == (out_ff.packet_status == ST_SYNC_LOSS)),
      "sync loss total disagrees with packet status")
   `TSPCC_ASSERT(a_forward_needs_stage,
      fwd_hit_ff |-> s1_valid_ff,
      "forwarded entry held with no packet in the checking stage")

endmodule
